// ===== rtl/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder axis position controller: shared package
// Types, widths, constants and field offsets for the controller and its
// port checker.
// ----------------------------------------------------------------------------
package epc_pkg;

	localparam int REVOLUTION_BITS  = 8;
	localparam int TARGET_FRAC_BITS = 4;

	localparam int DUTY_W    = 16;
	localparam int TOL_W     = 8;
	localparam int TARGET_W  = 18;
	localparam int COUNT_W   = 16;
	localparam int POS_OUT_W = 13;
	localparam int QUOT_W    = 5;

	localparam int POS_W     = REVOLUTION_BITS + QUOT_W;
	localparam int SHIFTED_W = POS_W + TARGET_FRAC_BITS;
	localparam int ERR_W     = ((TARGET_W > SHIFTED_W + 1) ? TARGET_W : SHIFTED_W + 1) + 1;

	localparam logic [COUNT_W-1:0] WRAP_HIGH = 16'd61680;
	localparam logic [COUNT_W-1:0] WRAP_LOW  = 16'd3855;
	localparam int                 MM_PER_REV_SHIFT = 4;

	// Reciprocal of 3855 scaled by 2**28; exact floor over the whole 16-bit range.
	localparam int                 RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP_MUL   = 17'd69634;
	localparam int                 RECIP_SHIFT = 28;
	localparam int                 PROD_W      = COUNT_W + RECIP_W;

	localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd130;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 8'd24;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam int OP_W        = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam int IN_TARGET_LSB = 0;
	localparam int IN_COUNT_LSB  = IN_TARGET_LSB + TARGET_W;
	localparam int IN_SWITCH_BIT = IN_COUNT_LSB + COUNT_W;

	localparam int OUT_PWM_LSB   = 0;
	localparam int OUT_HOME_BIT  = OUT_PWM_LSB + DUTY_W;
	localparam int OUT_ENA_BIT   = OUT_HOME_BIT + 1;
	localparam int OUT_POS_LSB   = OUT_ENA_BIT + 1;
	localparam int OUT_DONE_BIT  = OUT_POS_LSB + POS_OUT_W;
	localparam int OUT_CLEAR_BIT = OUT_DONE_BIT + 1;
	localparam int OUT_BUSY_BIT  = OUT_CLEAR_BIT + 1;
	localparam int OUT_USED_W    = OUT_BUSY_BIT + 1;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_HOMING,
		MODE_MOVING
	} mode_t;

	typedef enum logic [OP_W-1:0] {
		OP_HOME,
		OP_MOVE,
		OP_TICK
	} opcode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_DRIVE_DUTY,
		CFG_TOLERANCE
	} cfg_addr_t;

	typedef struct packed {
		logic [OP_W-1:0]            opcode;
		logic signed [TARGET_W-1:0] target;
		logic [QUOT_W-1:0]          quot;
		logic                       above_high;
		logic                       below_low;
		logic                       home_switch;
	} item_t;

endpackage

// ===== rtl/encoder_axis_position_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Encoder axis position controller
// Bang-bang single-axis controller working from a 16-bit quadrature count.
// ----------------------------------------------------------------------------
// Commands and encoder samples arrive on the s_axis channel, one transfer per
// item: tuser carries the opcode (home, move, tick) and tdata the move target,
// the encoder count and the home switch. Every item yields exactly one
// transfer on m_axis with the drive outputs, the position in millimetres and
// the done, clear-count and busy flags.
// The configuration port writes the drive duty and the stop tolerance. The user
// must write it only while no item is in flight; the block does not enforce it.
// An accepted item is held in the input register, evaluated combinationally
// against the controller state and placed in the output register when that
// register is free. One item is accepted per cycle for as long as the receiver
// keeps up; the encoder count is divided by the counts per millimetre with a
// reciprocal multiply ahead of the input register.
// When the receiver stalls, the output register holds its transfer and the
// input register still takes one further item before s_axis_tready falls.
// Reset empties both registers, returns the controller to idle with zero
// revolutions and an armed wrap detector, and restores the register defaults.
// ----------------------------------------------------------------------------
module encoder_axis_position_controller_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// target_pos [17:0], encoder_count [33:18], home_switch [34], zero [39:35]
	input  logic [epc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// opcode [1:0]
	input  logic [epc_pkg::OP_W-1:0]              s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pwm_compare [15:0], toward_home [16], motor_enable [17], position_mm [30:18],
	// done_res [31], clear_count [32], busy_res [33], zero [39:34]
	output logic [epc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [epc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [epc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	logic [epc_pkg::DUTY_W-1:0]          drive_duty_q;
	logic [epc_pkg::TOL_W-1:0]           tolerance_q;
	epc_pkg::mode_t                      mode_q, mode_d;
	logic signed [epc_pkg::TARGET_W-1:0] target_q, target_d;
	logic [epc_pkg::REVOLUTION_BITS-1:0] revs_q, revs_d;
	logic                                armed_q, armed_d;
	logic                                dir_home_q, dir_home_d;

	epc_pkg::item_t                      item_in;
	epc_pkg::item_t                      item_s1;
	logic                                valid_s1;
	logic                                valid_s2;
	logic [epc_pkg::OUT_TDATA_W-1:0]     tdata_s2;
	logic [epc_pkg::OUT_TDATA_W-1:0]     tdata_next;

	logic                                out_free;
	logic                                advance;
	logic                                accept;

	logic [epc_pkg::COUNT_W-1:0]         count_in;
	logic [epc_pkg::PROD_W-1:0]          quot_prod;

	logic signed [epc_pkg::TARGET_W-1:0] eval_target;
	logic [epc_pkg::POS_W-1:0]           pos_full;
	logic [epc_pkg::SHIFTED_W-1:0]       pos_shifted;
	logic signed [epc_pkg::ERR_W-1:0]    err;
	logic [epc_pkg::ERR_W-1:0]           err_mag;
	logic                                in_window;
	logic                                done;
	logic                                clear;
	logic                                pos_zero;
	logic                                driving;
	logic [epc_pkg::POS_W+epc_pkg::POS_OUT_W-1:0] pos_wide;
	logic [epc_pkg::POS_OUT_W-1:0]       pos_out;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = tdata_s2;

	assign count_in  = s_axis_tdata[epc_pkg::IN_COUNT_LSB +: epc_pkg::COUNT_W];
	assign quot_prod = epc_pkg::PROD_W'(count_in) * epc_pkg::PROD_W'(epc_pkg::RECIP_MUL);

	always_comb begin
		item_in.opcode      = s_axis_tuser;
		item_in.target      = s_axis_tdata[epc_pkg::IN_TARGET_LSB +: epc_pkg::TARGET_W];
		item_in.quot        = epc_pkg::QUOT_W'(quot_prod >> epc_pkg::RECIP_SHIFT);
		item_in.above_high  = count_in > epc_pkg::WRAP_HIGH;
		item_in.below_low   = count_in < epc_pkg::WRAP_LOW;
		item_in.home_switch = s_axis_tdata[epc_pkg::IN_SWITCH_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_duty_q <= epc_pkg::DUTY_RESET;
			tolerance_q  <= epc_pkg::TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				epc_pkg::CFG_DRIVE_DUTY: drive_duty_q <= cfg_wdata[epc_pkg::DUTY_W-1:0];
				epc_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_wdata[epc_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Revs, wrap tracked only on moving ticks; a homing switch tick clears revs.
	always_comb begin
		revs_d  = revs_q;
		armed_d = armed_q;
		if (item_s1.opcode == epc_pkg::OP_TICK && mode_q == epc_pkg::MODE_MOVING) begin
			if (!dir_home_q) begin
				if (item_s1.above_high && armed_q) begin
					armed_d = 1'b0;
				end else if (item_s1.below_low && !armed_q) begin
					armed_d = 1'b1;
					revs_d  = revs_q + 1'b1;
				end
			end else begin
				if (item_s1.below_low) begin
					armed_d = 1'b0;
				end else if (item_s1.above_high && !armed_q) begin
					armed_d = 1'b1;
					revs_d  = revs_q - 1'b1;
				end
			end
		end else if (item_s1.opcode == epc_pkg::OP_TICK && mode_q == epc_pkg::MODE_HOMING
				&& item_s1.home_switch) begin
			revs_d = '0;
		end
	end

	assign pos_full = (epc_pkg::POS_W'(revs_d) << epc_pkg::MM_PER_REV_SHIFT)
		+ epc_pkg::POS_W'(revs_d) + epc_pkg::POS_W'(item_s1.quot);
	assign pos_shifted = epc_pkg::SHIFTED_W'(pos_full) << epc_pkg::TARGET_FRAC_BITS;
	assign eval_target = (item_s1.opcode == epc_pkg::OP_MOVE) ? item_s1.target : target_q;
	assign err       = epc_pkg::ERR_W'(eval_target) - $signed(epc_pkg::ERR_W'(pos_shifted));
	assign err_mag   = err[epc_pkg::ERR_W-1] ? epc_pkg::ERR_W'(-err) : epc_pkg::ERR_W'(err);
	assign in_window = err_mag <= epc_pkg::ERR_W'(tolerance_q);

	// Next controller state.
	always_comb begin
		mode_d     = mode_q;
		target_d   = target_q;
		dir_home_d = dir_home_q;
		done       = 1'b0;
		clear      = 1'b0;
		pos_zero   = 1'b0;
		case (item_s1.opcode)
			epc_pkg::OP_HOME: begin
				mode_d     = epc_pkg::MODE_HOMING;
				dir_home_d = 1'b1;
			end
			epc_pkg::OP_MOVE: begin
				target_d = item_s1.target;
				if (in_window) begin
					mode_d = epc_pkg::MODE_IDLE;
					done   = 1'b1;
				end else begin
					mode_d     = epc_pkg::MODE_MOVING;
					dir_home_d = err[epc_pkg::ERR_W-1];
				end
			end
			epc_pkg::OP_TICK: begin
				case (mode_q)
					epc_pkg::MODE_HOMING: begin
						dir_home_d = 1'b1;
						if (item_s1.home_switch) begin
							mode_d   = epc_pkg::MODE_IDLE;
							done     = 1'b1;
							clear    = 1'b1;
							pos_zero = 1'b1;
						end
					end
					epc_pkg::MODE_MOVING: begin
						if (in_window) begin
							mode_d = epc_pkg::MODE_IDLE;
							done   = 1'b1;
						end else begin
							dir_home_d = err[epc_pkg::ERR_W-1];
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Result item.
	always_comb begin
		driving  = (mode_d == epc_pkg::MODE_HOMING) || (mode_d == epc_pkg::MODE_MOVING);
		pos_wide = pos_zero ? '0 : (epc_pkg::POS_W + epc_pkg::POS_OUT_W)'(pos_full);
		pos_out  = pos_wide[epc_pkg::POS_OUT_W-1:0];
		tdata_next = '0;
		tdata_next[epc_pkg::OUT_PWM_LSB +: epc_pkg::DUTY_W] = driving ? drive_duty_q : '0;
		tdata_next[epc_pkg::OUT_HOME_BIT]                   = dir_home_d;
		tdata_next[epc_pkg::OUT_ENA_BIT]                    = driving;
		tdata_next[epc_pkg::OUT_POS_LSB +: epc_pkg::POS_OUT_W] = pos_out;
		tdata_next[epc_pkg::OUT_DONE_BIT]                   = done;
		tdata_next[epc_pkg::OUT_CLEAR_BIT]                  = clear;
		tdata_next[epc_pkg::OUT_BUSY_BIT]                   = driving;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= epc_pkg::MODE_IDLE;
			target_q   <= '0;
			revs_q     <= '0;
			armed_q    <= 1'b1;
			dir_home_q <= 1'b0;
		end else if (advance) begin
			mode_q     <= mode_d;
			target_q   <= target_d;
			revs_q     <= revs_d;
			armed_q    <= armed_d;
			dir_home_q <= dir_home_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			tdata_s2 <= tdata_next;
		end
	end

endmodule

// ===== rtl/epc_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder axis position controller: port checker
// Watches the result channel for consistent flags and stable stalled transfers.
// ----------------------------------------------------------------------------
module epc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [epc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic busy;
	logic enable;
	logic done;
	logic clear;
	logic toward_home;
	logic [epc_pkg::DUTY_W-1:0]    pwm;
	logic [epc_pkg::POS_OUT_W-1:0] pos;

	assign busy        = m_axis_tdata[epc_pkg::OUT_BUSY_BIT];
	assign enable      = m_axis_tdata[epc_pkg::OUT_ENA_BIT];
	assign done        = m_axis_tdata[epc_pkg::OUT_DONE_BIT];
	assign clear       = m_axis_tdata[epc_pkg::OUT_CLEAR_BIT];
	assign toward_home = m_axis_tdata[epc_pkg::OUT_HOME_BIT];
	assign pwm         = m_axis_tdata[epc_pkg::OUT_PWM_LSB +: epc_pkg::DUTY_W];
	assign pos         = m_axis_tdata[epc_pkg::OUT_POS_LSB +: epc_pkg::POS_OUT_W];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result transfer changed.");

	a_drive_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !enable |-> !busy && pwm == '0)
		else $error("Drive output active while the motor is disabled.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && done |-> !busy && !enable)
		else $error("Completion reported while still busy.");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && clear |-> done && toward_home && pos == '0)
		else $error("Counter clear without a completed homing run.");

endmodule

bind encoder_axis_position_controller_unit epc_checker u_epc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_encoder_axis_position_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Encoder axis position controller: self-checking testbench
// Commands and encoder samples go in on s_axis from a queue of pending
// commands, with random gaps on the sending side and random back-pressure on
// m_axis. Each accepted transfer is run through a local model of the
// controller. Every output transfer is checked field by field against the
// oldest predicted status. Directed cases come first, then random homing and
// move sequences and single random commands over a drifting encoder count,
// under several register settings.
// ----------------------------------------------------------------------------
module tb_encoder_axis_position_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [epc_pkg::OP_W-1:0] OP_NOP = 2'd3;

	typedef struct {
		logic [epc_pkg::OP_W-1:0]            op;
		logic signed [epc_pkg::TARGET_W-1:0] target;
		logic [epc_pkg::COUNT_W-1:0]         count;
		logic                                home_sw;
	} cmd_t;

	typedef struct {
		logic [epc_pkg::DUTY_W-1:0]    pwm;
		logic                          toward_home;
		logic                          motor_on;
		logic [epc_pkg::POS_OUT_W-1:0] pos_mm;
		logic                          done;
		logic                          clear;
		logic                          busy;
	} status_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [epc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [epc_pkg::OP_W-1:0]        s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [epc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            cfg_we = 1'b0;
	logic [epc_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [epc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	cmd_t    pending_cmds[$];
	status_t expected_status[$];
	int      mismatch_count = 0;

	// Local copy of the controller state and registers.
	logic [epc_pkg::DUTY_W-1:0]          ctl_duty = epc_pkg::DUTY_RESET;
	logic [epc_pkg::TOL_W-1:0]           ctl_tol = epc_pkg::TOL_RESET;
	epc_pkg::mode_t                      ctl_mode = epc_pkg::MODE_IDLE;
	logic signed [epc_pkg::TARGET_W-1:0] ctl_target = '0;
	logic [epc_pkg::REVOLUTION_BITS-1:0] ctl_revs = '0;
	logic                                ctl_armed = 1'b1;
	logic                                ctl_home_dir = 1'b0;

	cmd_t drv_cmd;
	bit   drv_holding = 1'b0;
	int   drv_gap = 0;
	bit   drv_calm = 1'b0;
	int   mon_gap = 0;
	bit   mon_calm = 1'b0;

	logic [epc_pkg::COUNT_W-1:0] walk_cnt = '0;
	bit                          walk_up = 1'b1;

	encoder_axis_position_controller_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int mm_of(input logic [epc_pkg::COUNT_W-1:0] count);
		return int'(count) / 3855 + int'(ctl_revs) * 17;
	endfunction

	function automatic bit move_settles(input int pos);
		longint err;
		longint mag;
		err = longint'(ctl_target) - (longint'(pos) <<< epc_pkg::TARGET_FRAC_BITS);
		mag = (err < 0) ? -err : err;
		if (mag <= longint'(ctl_tol)) begin
			ctl_mode = epc_pkg::MODE_IDLE;
			return 1'b1;
		end
		ctl_home_dir = (err < 0);
		return 1'b0;
	endfunction

	function automatic void predict_status(input cmd_t c);
		status_t s;
		int      pos;
		bit      done_f;
		bit      clr_f;
		bit      drv_f;
		done_f = 1'b0;
		clr_f = 1'b0;
		case (c.op)
			epc_pkg::OP_HOME: begin
				ctl_mode = epc_pkg::MODE_HOMING;
				ctl_home_dir = 1'b1;
				pos = mm_of(c.count);
			end
			epc_pkg::OP_MOVE: begin
				ctl_target = c.target;
				ctl_mode = epc_pkg::MODE_MOVING;
				pos = mm_of(c.count);
				done_f = move_settles(pos);
			end
			epc_pkg::OP_TICK: begin
				if (ctl_mode == epc_pkg::MODE_HOMING) begin
					ctl_home_dir = 1'b1;
					if (c.home_sw) begin
						ctl_mode = epc_pkg::MODE_IDLE;
						ctl_revs = '0;
						done_f = 1'b1;
						clr_f = 1'b1;
						pos = 0;
					end else begin
						pos = mm_of(c.count);
					end
				end else if (ctl_mode == epc_pkg::MODE_MOVING) begin
					if (!ctl_home_dir) begin
						if (c.count > epc_pkg::WRAP_HIGH && ctl_armed) begin
							ctl_armed = 1'b0;
						end else if (c.count < epc_pkg::WRAP_LOW && !ctl_armed) begin
							ctl_armed = 1'b1;
							ctl_revs = ctl_revs + 1'b1;
						end
					end else begin
						if (c.count < epc_pkg::WRAP_LOW) begin
							ctl_armed = 1'b0;
						end else if (c.count > epc_pkg::WRAP_HIGH && !ctl_armed) begin
							ctl_armed = 1'b1;
							ctl_revs = ctl_revs - 1'b1;
						end
					end
					pos = mm_of(c.count);
					done_f = move_settles(pos);
				end else begin
					pos = mm_of(c.count);
				end
			end
			default: begin
				pos = mm_of(c.count);
			end
		endcase
		drv_f = (ctl_mode == epc_pkg::MODE_HOMING) || (ctl_mode == epc_pkg::MODE_MOVING);
		s.pwm = drv_f ? ctl_duty : '0;
		s.toward_home = ctl_home_dir;
		s.motor_on = drv_f;
		s.pos_mm = pos[epc_pkg::POS_OUT_W-1:0];
		s.done = done_f;
		s.clear = clr_f;
		s.busy = drv_f;
		expected_status.push_back(s);
	endfunction

	task automatic flag_mismatch(input string what, input logic [39:0] got,
		input logic [39:0] want);
		mismatch_count++;
		$display("%0t: %s differs: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [39:0] got,
		input logic [39:0] want);
		if (got !== want) begin
			flag_mismatch(what, got, want);
		end
	endtask

	task automatic check_status(input logic [epc_pkg::OUT_TDATA_W-1:0] d);
		status_t e;
		if (expected_status.size() == 0) begin
			flag_mismatch("transfer with nothing predicted", d, '0);
			return;
		end
		e = expected_status.pop_front();
		compare_field("pwm_compare", d[epc_pkg::OUT_PWM_LSB +: epc_pkg::DUTY_W], e.pwm);
		compare_field("toward_home", d[epc_pkg::OUT_HOME_BIT], e.toward_home);
		compare_field("motor_enable", d[epc_pkg::OUT_ENA_BIT], e.motor_on);
		compare_field("position_mm", d[epc_pkg::OUT_POS_LSB +: epc_pkg::POS_OUT_W], e.pos_mm);
		compare_field("done_res", d[epc_pkg::OUT_DONE_BIT], e.done);
		compare_field("clear_count", d[epc_pkg::OUT_CLEAR_BIT], e.clear);
		compare_field("busy_res", d[epc_pkg::OUT_BUSY_BIT], e.busy);
		compare_field("padding", d[epc_pkg::OUT_TDATA_W-1:epc_pkg::OUT_USED_W], '0);
	endtask

	// Sending side: one pending command at a time, with a random gap after each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			drv_holding = 1'b0;
			drv_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_status(drv_cmd);
				drv_holding = 1'b0;
				if ($urandom_range(0, 39) == 0) begin
					drv_calm = !drv_calm;
				end
				drv_gap = drv_calm ? 0 : $urandom_range(0, 8);
			end
			if (!drv_holding) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (pending_cmds.size() != 0) begin
					drv_cmd = pending_cmds.pop_front();
					drv_holding = 1'b1;
				end
			end
			s_axis_tvalid <= drv_holding;
			if (drv_holding) begin
				s_axis_tdata <= {5'b0, drv_cmd.home_sw, drv_cmd.count, drv_cmd.target};
				s_axis_tuser <= drv_cmd.op;
			end
		end
	end

	// Receiving side: checks each transfer, then stalls for a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			mon_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_status(m_axis_tdata);
				if ($urandom_range(0, 39) == 0) begin
					mon_calm = !mon_calm;
				end
				mon_gap = mon_calm ? 0 : $urandom_range(0, 8);
			end
			if (mon_gap > 0) begin
				mon_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_cmd(input logic [epc_pkg::OP_W-1:0] op, input int target,
		input int count, input bit sw);
		cmd_t c;
		c.op = op;
		c.target = target[epc_pkg::TARGET_W-1:0];
		c.count = count[epc_pkg::COUNT_W-1:0];
		c.home_sw = sw;
		pending_cmds.push_back(c);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || drv_holding || expected_status.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input epc_pkg::cfg_addr_t addr,
		input logic [epc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == epc_pkg::CFG_DRIVE_DUTY) begin
			ctl_duty = data[epc_pkg::DUTY_W-1:0];
		end else begin
			ctl_tol = data[epc_pkg::TOL_W-1:0];
		end
	endtask

	function automatic void walk_encoder();
		if ($urandom_range(0, 7) == 0) begin
			walk_up = !walk_up;
		end
		if (walk_up) begin
			walk_cnt = walk_cnt + epc_pkg::COUNT_W'($urandom_range(0, 6000));
		end else begin
			walk_cnt = walk_cnt - epc_pkg::COUNT_W'($urandom_range(0, 6000));
		end
	endfunction

	function automatic int pick_target();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2) begin
			return (int'(walk_cnt) / 3855 + 17 * int'($urandom_range(0, 2))) * 16
				+ int'($urandom_range(0, 80)) - 40;
		end else if (r == 2) begin
			return int'($urandom_range(0, 139264)) - 69632;
		end
		return $urandom;
	endfunction

	task automatic gen_random(input int n);
		int made;
		int r;
		int k;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				push_cmd(epc_pkg::OP_HOME, $urandom, walk_cnt, $urandom_range(0, 1));
				made++;
				k = $urandom_range(0, 6);
				repeat (k) begin
					walk_encoder();
					push_cmd(epc_pkg::OP_TICK, $urandom, walk_cnt, 1'b0);
					made++;
				end
				if ($urandom_range(0, 9) != 0) begin
					push_cmd(epc_pkg::OP_TICK, $urandom, $urandom, 1'b1);
					made++;
				end
			end else if (r < 80) begin
				push_cmd(epc_pkg::OP_MOVE, pick_target(), walk_cnt, $urandom_range(0, 1));
				made++;
				k = $urandom_range(1, 24);
				repeat (k) begin
					walk_encoder();
					push_cmd(epc_pkg::OP_TICK, $urandom, walk_cnt, $urandom_range(0, 1));
					made++;
				end
			end else begin
				push_cmd(epc_pkg::OP_W'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom_range(0, 1));
				made++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Idle ticks, the unused opcode, then a full homing run.
		push_cmd(epc_pkg::OP_TICK, 0, 0, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 65535, 1'b1);
		push_cmd(OP_NOP, 0, 12345, 1'b0);
		push_cmd(epc_pkg::OP_HOME, 0, 40000, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 30000, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 20000, 1'b1);
		// A move already on target, then a forward move over both wrap thresholds.
		push_cmd(epc_pkg::OP_MOVE, 0, 0, 1'b0);
		push_cmd(epc_pkg::OP_MOVE, 131071, 0, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 61680, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 61681, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 3855, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 3854, 1'b0);
		push_cmd(OP_NOP, 0, 100, 1'b1);
		// Reverse move: back to zero revolutions and then below it.
		push_cmd(epc_pkg::OP_MOVE, -131072, 5000, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 3854, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 61681, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 2000, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 65535, 1'b0);
		// Commands that replace a running one.
		push_cmd(epc_pkg::OP_HOME, 0, 100, 1'b0);
		push_cmd(epc_pkg::OP_MOVE, 69632, 0, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 65535, 1'b1);
		push_cmd(epc_pkg::OP_HOME, 0, 0, 1'b0);
		push_cmd(epc_pkg::OP_TICK, 0, 0, 1'b1);
		gen_random(200);
		wait_drained();

		write_reg(epc_pkg::CFG_DRIVE_DUTY, 16'hFFFF);
		write_reg(epc_pkg::CFG_TOLERANCE, 16'h0000);
		gen_random(200);
		wait_drained();

		write_reg(epc_pkg::CFG_DRIVE_DUTY, 16'h0000);
		write_reg(epc_pkg::CFG_TOLERANCE, 16'h00FF);
		gen_random(200);
		wait_drained();

		write_reg(epc_pkg::CFG_DRIVE_DUTY, epc_pkg::CFG_DATA_W'($urandom));
		write_reg(epc_pkg::CFG_TOLERANCE, epc_pkg::CFG_DATA_W'($urandom_range(0, 255)));
		gen_random(200);
		wait_drained();

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
